// File: src/cone_direction_velocity_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cone direction velocity sampler
// Clock and reset names follow the house convention (i_clk, i_rst_n).
// ----------------------------------------------------------------------------
`ifndef CONE_DIRECTION_VELOCITY_SAMPLER_UNIT_MACROS_SVH
`define CONE_DIRECTION_VELOCITY_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CDVS_ASSERT_IMPL(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication, checked outside reset
`define CDVS_ASSERT_NEXT(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// File: src/cdvs_pkg.sv
// ----------------------------------------------------------------------------
// cdvs_pkg
// Shared types, constants and CORDIC helpers of the cone velocity sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdvs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 15;
    localparam int NITER        = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // register indexes
    localparam logic [2:0] REG_DIR_X     = 3'd0;
    localparam logic [2:0] REG_DIR_Y     = 3'd1;
    localparam logic [2:0] REG_DIR_Z     = 3'd2;
    localparam logic [2:0] REG_ANGLE_MIN = 3'd3;
    localparam logic [2:0] REG_ANGLE_MAX = 3'd4;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        logic               neg;
    } t_cord;

    // rotation matrix (row major, Q2.14) and the two polar cosine bounds
    typedef struct packed {
        logic [8:0][15:0] m;
        logic [15:0]      cos_hi;
        logic [15:0]      cos_lo;
    } t_coef;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:    return 32'h20000000;
            5'd1:    return 32'h12E4051E;
            5'd2:    return 32'h09FB385B;
            5'd3:    return 32'h051111D4;
            5'd4:    return 32'h028B0D43;
            5'd5:    return 32'h0145D7E1;
            5'd6:    return 32'h00A2F61E;
            5'd7:    return 32'h00517C55;
            5'd8:    return 32'h0028BE53;
            5'd9:    return 32'h00145F2F;
            5'd10:   return 32'h000A2F98;
            5'd11:   return 32'h000517CC;
            5'd12:   return 32'h00028BE6;
            5'd13:   return 32'h000145F3;
            5'd14:   return 32'h0000A2F9;
            5'd15:   return 32'h0000517C;
            5'd16:   return 32'h000028BE;
            5'd17:   return 32'h0000145F;
            5'd18:   return 32'h00000A2F;
            5'd19:   return 32'h00000517;
            5'd20:   return 32'h0000028B;
            5'd21:   return 32'h00000145;
            5'd22:   return 32'h000000A2;
            5'd23:   return 32'h00000051;
            default: return 32'h00000000;
        endcase
    endfunction

    // fold the left half plane onto the right one, remember to negate
    function automatic t_cord cordic_init(input logic [31:0] ang);
        t_cord       o;
        logic [31:0] a2;
        o.neg = ang[31] ^ ang[30];
        a2    = o.neg ? (ang + 32'h80000000) : ang;
        o.x   = CORDIC_GAIN;
        o.y   = '0;
        o.z   = $signed({a2[31], a2});
        return o;
    endfunction

    function automatic t_cord cordic_step(input t_cord s, input logic [4:0] i);
        t_cord              o;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] at;
        dx = $signed(s.y) >>> i;
        dy = $signed(s.x) >>> i;
        at = $signed({1'b0, atan_turn(i)});
        o  = s;
        if (!s.z[32]) begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - at;
        end else begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + at;
        end
        return o;
    endfunction

    // Q30 to Q2.14, rounded, clamped to +-1.0
    function automatic logic [15:0] cordic_out(input logic signed [32:0] v, input logic neg);
        logic signed [33:0] w;
        logic signed [33:0] t;
        w = neg ? -$signed({v[32], v}) : $signed({v[32], v});
        t = (w + 34'sd32768) >>> 16;
        if (t > 34'sd16384) begin
            return 16'h4000;
        end else if (t < -34'sd16384) begin
            return 16'hC000;
        end
        return t[15:0];
    endfunction

endpackage

// File: src/cdvs_cfg.sv
// ----------------------------------------------------------------------------
// cdvs_cfg
// Register file and the sequencer that rebuilds the rotation matrix and the
// polar cosine bounds after each register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdvs_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [4:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_busy,
    output cdvs_pkg::t_coef     o_coef
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_SQRT  = 3'd2;
    localparam logic [2:0] ST_DLOAD = 3'd3;
    localparam logic [2:0] ST_DRUN  = 3'd4;
    localparam logic [2:0] ST_PROD  = 3'd5;
    localparam logic [2:0] ST_CLOAD = 3'd6;
    localparam logic [2:0] ST_COS   = 3'd7;

    logic [15:0] r_dir_x, r_dir_y, r_dir_z, r_amin, r_amax;
    logic [2:0]  r_st;
    logic [5:0]  r_cnt;
    logic [2:0]  r_job;
    logic [47:0] r_acc;
    logic [47:0] r_sr;
    logic [23:0] r_nq;
    logic signed [15:0] r_ux, r_uy, r_uz, r_off, r_m0, r_m4, r_c0;
    logic [28:0] r_sx2, r_sy2;
    logic [29:0] r_s2;
    logic signed [29:0] r_p;
    logic signed [44:0] r_nm0, r_nm1, r_nm2;
    logic [44:0] r_dnum, r_dq;
    logic [30:0] r_drem;
    logic [29:0] r_dden;
    logic        r_dneg;
    cdvs_pkg::t_cord r_cs;
    cdvs_pkg::t_coef r_coef;

    logic        wr;
    logic [2:0]  widx;
    logic [1:0]  dsel;
    logic signed [15:0] sel_dir;
    logic signed [29:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [46:0] mul_p;
    logic [47:0] n_acc_sq;
    logic [5:0]  sq_sh;
    logic [47:0] sq_bit, sq_rb, n_acc, n_sr;
    logic        sq_ge;
    logic signed [16:0] dl_d, dl_mag;
    logic signed [44:0] dl_nm, dl_nmag;
    logic [44:0] dl_num;
    logic [29:0] dl_den;
    logic        dl_neg;
    logic [30:0] dv_sh;
    logic        dv_ge;
    logic [44:0] dv_q;
    logic [15:0] dv_mag;
    logic signed [15:0] dv_val;
    logic [15:0] ang_lo, ang_hi;
    cdvs_pkg::t_cord cs_n;
    logic [15:0] cs_out;
    logic        last_div, last_cos;

    assign wr   = i_psel & i_penable & i_pwrite;
    assign widx = i_paddr[4:2];

    always_comb begin
        case (widx)
            cdvs_pkg::REG_DIR_X:     o_prdata = {16'd0, r_dir_x};
            cdvs_pkg::REG_DIR_Y:     o_prdata = {16'd0, r_dir_y};
            cdvs_pkg::REG_DIR_Z:     o_prdata = {16'd0, r_dir_z};
            cdvs_pkg::REG_ANGLE_MIN: o_prdata = {16'd0, r_amin};
            cdvs_pkg::REG_ANGLE_MAX: o_prdata = {16'd0, r_amax};
            default:                 o_prdata = 32'd0;
        endcase
    end

    // pick the axis component by counter while squaring, by job while dividing
    assign dsel = (r_st == ST_SQ) ? r_cnt[1:0] : r_job[1:0];
    always_comb begin
        case (dsel)
            2'd0:    sel_dir = $signed(r_dir_x);
            2'd1:    sel_dir = $signed(r_dir_y);
            default: sel_dir = $signed(r_dir_z);
        endcase
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_st == ST_SQ) begin
            mul_a = 30'(sel_dir);
            mul_b = 17'(sel_dir);
        end else if (r_st == ST_PROD) begin
            case (r_cnt[2:0])
                3'd0: begin mul_a = 30'(r_ux); mul_b = 17'(r_ux); end
                3'd1: begin mul_a = 30'(r_uy); mul_b = 17'(r_uy); end
                3'd2: begin mul_a = 30'(r_ux); mul_b = 17'(r_uy); end
                3'd3: begin mul_a = r_p; mul_b = 17'sd16384 - 17'(r_uz); end
                3'd4: begin mul_a = $signed({1'b0, r_sx2}); mul_b = 17'(r_uz); end
                default: begin mul_a = $signed({1'b0, r_sy2}); mul_b = 17'(r_uz); end
            endcase
        end
    end
    assign mul_p    = mul_a * mul_b;
    assign n_acc_sq = r_acc + 48'(mul_p[31:0]);

    // integer square root, two bits of radicand a step
    assign sq_sh  = 6'd46 - {r_cnt[4:0], 1'b0};
    assign sq_bit = 48'd1 << sq_sh;
    assign sq_rb  = r_sr + sq_bit;
    assign sq_ge  = r_acc >= sq_rb;
    assign n_acc  = sq_ge ? (r_acc - sq_rb) : r_acc;
    assign n_sr   = sq_ge ? ((r_sr >> 1) + sq_bit) : (r_sr >> 1);

    // divider operands: normalize jobs then matrix jobs, rounded half away
    assign dl_d   = 17'(sel_dir);
    assign dl_mag = dl_d[16] ? -dl_d : dl_d;
    always_comb begin
        case (r_job)
            3'd3:    dl_nm = r_nm0;
            3'd4:    dl_nm = r_nm1;
            default: dl_nm = r_nm2;
        endcase
    end
    assign dl_nmag = dl_nm[44] ? -dl_nm : dl_nm;
    always_comb begin
        if (r_job < 3'd3) begin
            dl_num = (45'(dl_mag) << 22) + 45'(r_nq[23:1]);
            dl_den = 30'(r_nq);
            dl_neg = dl_d[16];
        end else begin
            dl_num = 45'(dl_nmag) + 45'(r_s2[29:1]);
            dl_den = r_s2;
            dl_neg = dl_nm[44];
        end
    end

    assign dv_sh  = {r_drem[29:0], r_dnum[44]};
    assign dv_ge  = dv_sh >= {1'b0, r_dden};
    assign dv_q   = {r_dq[43:0], dv_ge};
    assign dv_mag = (dv_q > 45'd16384) ? 16'd16384 : dv_q[15:0];
    assign dv_val = r_dneg ? -$signed(dv_mag) : $signed(dv_mag);
    assign last_div = (r_cnt == 6'd44);

    // angle bounds in order, swapped when angle_max is below angle_min
    assign ang_lo = (r_amax < r_amin) ? r_amax : r_amin;
    assign ang_hi = (r_amax < r_amin) ? r_amin : r_amax;
    assign cs_n     = cdvs_pkg::cordic_step(r_cs, r_cnt[4:0]);
    assign cs_out   = cdvs_pkg::cordic_out(cs_n.x, cs_n.neg);
    assign last_cos = (r_cnt == 6'(cdvs_pkg::CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= 16'd16384;
            r_amin  <= '0;
            r_amax  <= '0;
            r_st    <= ST_IDLE;
            r_cnt   <= '0;
            r_job   <= '0;
            r_coef  <= '0;
        end else if (wr && (widx <= cdvs_pkg::REG_ANGLE_MAX)) begin
            case (widx)
                cdvs_pkg::REG_DIR_X:     r_dir_x <= i_pwdata[15:0];
                cdvs_pkg::REG_DIR_Y:     r_dir_y <= i_pwdata[15:0];
                cdvs_pkg::REG_DIR_Z:     r_dir_z <= i_pwdata[15:0];
                cdvs_pkg::REG_ANGLE_MIN: r_amin  <= i_pwdata[15:0];
                default:                 r_amax  <= i_pwdata[15:0];
            endcase
            // restart the rebuild from scratch
            r_st  <= ST_SQ;
            r_cnt <= '0;
        end else begin
            case (r_st)
                ST_SQ: begin
                    r_acc <= (r_cnt == 6'd0) ? 48'(mul_p[31:0]) : n_acc_sq;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd2) begin
                        r_cnt <= '0;
                        r_sr  <= '0;
                        if (n_acc_sq == 48'd0) begin
                            r_ux <= '0;
                            r_uy <= '0;
                            r_uz <= '0;
                            r_st <= ST_PROD;
                        end else begin
                            r_acc <= {n_acc_sq[31:0], 16'd0};
                            r_st  <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    r_acc <= n_acc;
                    r_sr  <= n_sr;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd23) begin
                        r_nq  <= n_sr[23:0];
                        r_job <= 3'd0;
                        r_st  <= ST_DLOAD;
                    end
                end
                ST_DLOAD: begin
                    r_dnum <= dl_num;
                    r_dden <= dl_den;
                    r_dneg <= dl_neg;
                    r_drem <= '0;
                    r_dq   <= '0;
                    r_cnt  <= '0;
                    r_st   <= ST_DRUN;
                end
                ST_DRUN: begin
                    r_drem <= dv_ge ? (dv_sh - {1'b0, r_dden}) : dv_sh;
                    r_dq   <= dv_q;
                    r_dnum <= {r_dnum[43:0], 1'b0};
                    r_cnt  <= r_cnt + 6'd1;
                    if (last_div) begin
                        r_job <= r_job + 3'd1;
                        r_st  <= ST_DLOAD;
                        case (r_job)
                            3'd0: r_ux <= dv_val;
                            3'd1: r_uy <= dv_val;
                            3'd2: begin r_uz <= dv_val; r_cnt <= '0; r_st <= ST_PROD; end
                            3'd3: r_off <= dv_val;
                            3'd4: r_m0 <= dv_val;
                            default: begin
                                r_m4  <= dv_val;
                                r_job <= 3'd0;
                                r_st  <= ST_CLOAD;
                            end
                        endcase
                    end
                end
                ST_PROD: begin
                    r_cnt <= r_cnt + 6'd1;
                    case (r_cnt[2:0])
                        3'd0: begin
                            // axis along z: diagonal matrix, no divisions
                            if (r_ux == 16'sd0 && r_uy == 16'sd0) begin
                                r_job <= 3'd0;
                                r_st  <= ST_CLOAD;
                            end
                            r_sx2 <= mul_p[28:0];
                        end
                        3'd1: r_sy2 <= mul_p[28:0];
                        3'd2: begin
                            r_p  <= mul_p[29:0];
                            r_s2 <= 30'(r_sx2) + 30'(r_sy2);
                        end
                        3'd3: r_nm0 <= -mul_p[44:0];
                        3'd4: r_nm1 <= $signed({2'b00, r_sy2, 14'd0}) + mul_p[44:0];
                        default: begin
                            r_nm2 <= $signed({2'b00, r_sx2, 14'd0}) + mul_p[44:0];
                            r_job <= 3'd3;
                            r_st  <= ST_DLOAD;
                        end
                    endcase
                end
                ST_CLOAD: begin
                    r_cs  <= cdvs_pkg::cordic_init((r_job == 3'd0) ? {1'b0, ang_lo, 15'd0}
                                                                  : {1'b0, ang_hi, 15'd0});
                    r_cnt <= '0;
                    r_st  <= ST_COS;
                end
                ST_COS: begin
                    r_cs  <= cs_n;
                    r_cnt <= r_cnt + 6'd1;
                    if (last_cos) begin
                        if (r_job == 3'd0) begin
                            r_c0  <= $signed(cs_out);
                            r_job <= 3'd1;
                            r_st  <= ST_CLOAD;
                        end else begin
                            r_coef.cos_hi <= r_c0;
                            r_coef.cos_lo <= cs_out;
                            if (r_ux == 16'sd0 && r_uy == 16'sd0) begin
                                r_coef.m <= {r_uz, 16'd0, 16'd0, 16'd0, r_uz, 16'd0,
                                             16'd0, 16'd0, r_uz};
                            end else begin
                                r_coef.m <= {r_uz, -r_uy, -r_ux, r_uy, r_m4, r_off,
                                             r_ux, r_off, r_m0};
                            end
                            r_st <= ST_IDLE;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != ST_IDLE);
    assign o_coef = r_coef;

endmodule

// File: src/cone_direction_velocity_sampler_unit.sv
// ----------------------------------------------------------------------------
// cone_direction_velocity_sampler_unit
// Streams velocity samples drawn uniformly inside a cone around an axis.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beat on the s_axis side: two random fractions and a speed. Output
//    beat on the m_axis side: the velocity vector, 8 fractional bits each.
//  - One output beat per input beat, in order. An accepted beat is registered
//    in stages A and B, the iteration stages, C to G and the output register.
//  - Throughput is one beat per cycle barring stalls and rebuilds: the azimuth
//    CORDIC and polar sine sqrt run side by side, one step per pipeline stage.
//  - Configuration goes over the APB port (dir_x/y/z, angle_min/max at 4*i).
//    Each write starts a rebuild of the matrix and cosine bounds on a shared
//    multiplier, a bit-serial divider and an iterative CORDIC; while it
//    runs, o_s_axis_tready is low. Write only when idle.
//  - Reset clears all valid bits and leaves the matrix and bounds at zero, so
//    the velocity is zero until the first register write.
//  - A receiver stall freezes the whole pipeline in place; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cone_direction_velocity_sampler_unit_macros.svh"

module cone_direction_velocity_sampler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // rand_cone, rand_azimuth, speed
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // vel_x, vel_y, vel_z, 2 pad bits
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NITER = cdvs_pkg::NITER;

    typedef struct packed {
        cdvs_pkg::t_cord    c;
        logic [28:0]        n;
        logic [29:0]        r;
        logic signed [16:0] a;
        logic [15:0]        spd;
    } t_it;

    cdvs_pkg::t_coef coef;
    logic            cfg_busy;
    logic            ce;

    cdvs_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_busy    (cfg_busy),
        .o_coef    (coef)
    );
    assign pready = 1'b1;

    // whole pipeline advances unless the output beat is held
    assign ce              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = ce && !cfg_busy;

    // ---- stage A: polar cosine between the bounds
    logic               r_va;
    logic signed [16:0] r_a_a;
    logic [15:0]        r_a_ra, r_a_spd;
    logic signed [16:0] cos_hi, cos_lo, diff;
    logic signed [33:0] prod_a;
    logic signed [17:0] n_a;

    assign cos_hi = 17'($signed(coef.cos_hi));
    assign cos_lo = 17'($signed(coef.cos_lo));
    assign diff   = cos_hi - cos_lo;
    assign prod_a = diff * $signed({1'b0, i_s_axis_tdata[15:0]});
    assign n_a    = 18'(cos_lo) + $signed(prod_a[33:16]);

    // ---- stage B: radicand 1 - a^2 and CORDIC start
    logic signed [33:0] n_asq;
    logic [33:0]        n_rad;
    assign n_asq = r_a_a * r_a_a;
    assign n_rad = 34'd268435456 - n_asq;

    t_it  r_it  [0:NITER];
    logic r_itv [0:NITER];

    // ---- iteration stages: one CORDIC step each, one root step below SQRT_STEPS
    for (genvar k = 0; k < NITER; k++) begin : g_iter
        localparam int SH = (k < cdvs_pkg::SQRT_STEPS) ? 2 * (cdvs_pkg::SQRT_STEPS - 1 - k) : 0;
        localparam logic [29:0] BITV = 30'd1 << SH;
        t_it        n_it;
        logic [29:0] rb;
        always_comb begin
            n_it = r_it[k];
            rb   = '0;
            if (k < cdvs_pkg::CORDIC_STEPS) begin
                n_it.c = cdvs_pkg::cordic_step(r_it[k].c, 5'(k));
            end
            if (k < cdvs_pkg::SQRT_STEPS) begin
                rb = r_it[k].r + BITV;
                if ({1'b0, r_it[k].n} >= rb) begin
                    n_it.n = r_it[k].n - rb[28:0];
                    n_it.r = (r_it[k].r >> 1) + BITV;
                end else begin
                    n_it.r = r_it[k].r >> 1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_it[k+1] <= n_it;
            end
        end
    end

    // ---- stage C: round CORDIC outputs, take the root
    logic               r_vc;
    logic signed [15:0] r_c_cp, r_c_sp;
    logic [14:0]        r_c_st;
    logic signed [16:0] r_c_a;
    logic [15:0]        r_c_spd;

    // ---- stage D: local x and y
    logic               r_vd;
    logic signed [16:0] r_d_lx, r_d_ly, r_d_lz;
    logic [15:0]        r_d_spd;
    logic signed [31:0] n_px, n_py;
    assign n_px = $signed({1'b0, r_c_st}) * r_c_cp + 32'sd8192;
    assign n_py = $signed({1'b0, r_c_st}) * r_c_sp + 32'sd8192;

    // ---- stage E: nine matrix products
    logic               r_ve;
    logic signed [32:0] r_e_p [0:8];
    logic [15:0]        r_e_spd;
    logic signed [32:0] n_p [0:8];
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            case (i % 3)
                0:       n_p[i] = $signed(coef.m[i]) * r_d_lx;
                1:       n_p[i] = $signed(coef.m[i]) * r_d_ly;
                default: n_p[i] = $signed(coef.m[i]) * r_d_lz;
            endcase
        end
    end

    // ---- stage F: row sums
    logic               r_vf;
    logic signed [34:0] r_f_dot [0:2];
    logic [15:0]        r_f_spd;

    // ---- stage G: scale by speed
    logic               r_vg;
    logic signed [51:0] r_g_pv [0:2];

    // ---- output register: round and saturate
    logic               r_ov;
    logic [17:0]        r_vel [0:2];
    logic [17:0]        n_vel [0:2];
    always_comb begin
        logic signed [52:0] sum;
        logic signed [24:0] sh;
        for (int r = 0; r < 3; r++) begin
            sum = 53'(r_g_pv[r]) + 53'sd134217728;
            sh  = sum[52:28];
            if (sh > 25'sd131071) begin
                n_vel[r] = 18'h1FFFF;
            end else if (sh < -25'sd131072) begin
                n_vel[r] = 18'h20000;
            end else begin
                n_vel[r] = sh[17:0];
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            for (int k = 0; k <= NITER; k++) begin
                r_itv[k] <= 1'b0;
            end
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_ov <= 1'b0;
        end else if (ce) begin
            r_va     <= i_s_axis_tvalid && o_s_axis_tready;
            r_itv[0] <= r_va;
            for (int k = 0; k < NITER; k++) begin
                r_itv[k+1] <= r_itv[k];
            end
            r_vc <= r_itv[NITER];
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
            r_vg <= r_vf;
            r_ov <= r_vg;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_a   <= n_a[16:0];
            r_a_ra  <= i_s_axis_tdata[31:16];
            r_a_spd <= i_s_axis_tdata[47:32];

            r_it[0].c   <= cdvs_pkg::cordic_init({r_a_ra, 16'd0});
            r_it[0].n   <= n_rad[28:0];
            r_it[0].r   <= '0;
            r_it[0].a   <= r_a_a;
            r_it[0].spd <= r_a_spd;

            r_c_cp  <= $signed(cdvs_pkg::cordic_out(r_it[NITER].c.x, r_it[NITER].c.neg));
            r_c_sp  <= $signed(cdvs_pkg::cordic_out(r_it[NITER].c.y, r_it[NITER].c.neg));
            r_c_st  <= r_it[NITER].r[14:0];
            r_c_a   <= r_it[NITER].a;
            r_c_spd <= r_it[NITER].spd;

            r_d_lx  <= n_px[30:14];
            r_d_ly  <= n_py[30:14];
            r_d_lz  <= r_c_a;
            r_d_spd <= r_c_spd;

            for (int i = 0; i < 9; i++) begin
                r_e_p[i] <= n_p[i];
            end
            r_e_spd <= r_d_spd;

            for (int r = 0; r < 3; r++) begin
                r_f_dot[r] <= 35'(r_e_p[3*r]) + 35'(r_e_p[3*r+1]) + 35'(r_e_p[3*r+2]);
                r_g_pv[r]  <= r_f_dot[r] * $signed({1'b0, r_f_spd});
                r_vel[r]   <= n_vel[r];
            end
            r_f_spd <= r_e_spd;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_vel[2], r_vel[1], r_vel[0]};

    `CDVS_ASSERT_NEXT(a_busy_no_entry, cfg_busy && ce, !r_va, "item entered during rebuild")
    `CDVS_ASSERT_NEXT(a_stall_holds, !ce, $stable(r_vc) && $stable(r_vg), "pipeline moved in stall")
    `CDVS_ASSERT_NEXT(a_drain, r_ov && i_m_axis_tready && !r_vg, !r_ov, "output beat repeated")

endmodule
